// ===== rtl/color_gradient_lookup_macros.svh =====
// Assertion macros shared by the colour gradient lookup RTL.
`ifndef COLOR_GRADIENT_LOOKUP_MACROS_SVH
`define COLOR_GRADIENT_LOOKUP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CGL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("colour gradient lookup check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CGL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("colour gradient lookup check failed");

`endif

// ===== rtl/cgl_pkg.sv =====
// Package with constants shared by the colour gradient lookup RTL.
package cgl_pkg;
    localparam int MAX_STOPS_DEF = 128;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 7;
    localparam int IN_DATA_W = 56;
    localparam int OUT_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_SPLINE_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 1'b1;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;
endpackage

// ===== rtl/cgl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module cgl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/color_gradient_lookup.sv =====
// Top level of the colour gradient lookup: stop table, segment search, division and blend.
// A write beat stores one stop. A lookup beat walks the stop table from the start,
// reading and then checking each stop examined, since the stop memory has a registered
// read, then reads the lower stop, runs a serial division for the fraction, forms the
// weight in the square and weight states and blends the three channels one after another
// through one shared multiplier; the division is skipped when the fraction is clamped to
// zero or one, and a stop count below two returns the colour of stop 0 without a blend.
// One item is worked on at a time; a finished colour waits in the output register while the
// next beat is taken. The stop memory is not cleared: only written stops may be looked up.
`include "color_gradient_lookup_macros.svh"
module color_gradient_lookup #(
    parameter int MAX_STOPS = cgl_pkg::MAX_STOPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cgl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cgl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // stop_index[6:0], stop_red[14:7], stop_green[22:15], stop_blue[30:23],
    // stop_position[38:31], position[54:39], zero fill[55].
    input  logic [cgl_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // operation[0].
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16].
    output logic [cgl_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import cgl_pkg::*;

    localparam int AW = $clog2(MAX_STOPS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_HI_RD  = 4'd1;
    localparam logic [3:0] S_HI_CHK = 4'd2;
    localparam logic [3:0] S_LO_RD  = 4'd3;
    localparam logic [3:0] S_LO_CAP = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_SQ     = 4'd6;
    localparam logic [3:0] S_WT     = 4'd7;
    localparam logic [3:0] S_BLEND  = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]  r_state, n_state;
    logic        r_mode;
    logic [6:0]  r_count;
    logic [AW-1:0] r_i;
    logic        r_single;
    logic [15:0] r_pos;
    logic [31:0] r_hi_ent, r_lo_ent;
    logic [15:0] r_rem, r_den, r_q;
    logic [3:0]  r_cnt;
    logic [16:0] r_d;
    logic [33:0] r_sq;
    logic [48:0] r_w;
    logic [1:0]  r_ch;
    logic [23:0] r_res;
    logic        r_ov;
    logic [23:0] r_out;

    logic        in_acc, wr_en;
    logic [6:0]  wr_idx;
    logic [AW-1:0] rd_addr;
    logic [31:0] rd_data;
    logic [7:0]  n_stops;
    logic [7:0]  i_ext;
    logic [15:0] rd_pos16, lo16, hi16, num, den;
    logic        num_neg, den_neg;
    logic [16:0] rem2;
    logic [51:0] cube;
    logic [7:0]  c1, c2;
    logic signed [8:0]  diff;
    logic signed [58:0] prod;
    logic [7:0]  blend_res;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign wr_idx = s_axis_tdata[6:0];
    assign wr_en = in_acc && (s_axis_tuser == OP_WRITE)
        && ({1'b0, wr_idx} < 8'(MAX_STOPS));

    assign rd_addr = (r_state == S_HI_RD) ? AW'(r_i + 1'b1) : r_i;

    cgl_ram #(.WIDTH(32), .DEPTH(MAX_STOPS)) u_stop_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_idx[AW-1:0]),
        .i_wdata ({s_axis_tdata[38:31], s_axis_tdata[14:7], s_axis_tdata[22:15],
                   s_axis_tdata[30:23]}),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign n_stops = ({1'b0, r_count} > 8'(MAX_STOPS)) ? 8'(MAX_STOPS) : {1'b0, r_count};
    assign i_ext = 8'(r_i);
    assign rd_pos16 = {rd_data[31:24], rd_data[31:24]};
    assign lo16 = {rd_data[31:24], rd_data[31:24]};
    assign hi16 = {r_hi_ent[31:24], r_hi_ent[31:24]};
    assign num_neg = r_pos < lo16;
    assign den_neg = hi16 < lo16;
    assign num = num_neg ? 16'(lo16 - r_pos) : 16'(r_pos - lo16);
    assign den = den_neg ? 16'(lo16 - hi16) : 16'(hi16 - lo16);
    assign rem2 = {r_rem, 1'b0};
    assign cube = r_sq * (18'd196608 - {r_d, 1'b0});

    always_comb begin
        c1 = r_lo_ent[23:16];
        c2 = r_hi_ent[23:16];
        unique case (r_ch)
            2'd0: begin
                c1 = r_lo_ent[23:16];
                c2 = r_hi_ent[23:16];
            end
            2'd1: begin
                c1 = r_lo_ent[15:8];
                c2 = r_hi_ent[15:8];
            end
            default: begin
                c1 = r_lo_ent[7:0];
                c2 = r_hi_ent[7:0];
            end
        endcase
    end

    assign diff = $signed({1'b0, c2}) - $signed({1'b0, c1});
    assign prod = 59'(diff * $signed({1'b0, r_w}));
    assign blend_res = 8'(c1 + 8'(prod >>> 48));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_acc && s_axis_tuser == OP_LOOKUP) begin
                n_state = (n_stops < 8'd2) ? S_LO_RD : S_HI_RD;
            end
            S_HI_RD:  n_state = S_HI_CHK;
            S_HI_CHK: n_state = ((i_ext + 8'd2 < n_stops) && (rd_pos16 < r_pos))
                ? S_HI_RD : S_LO_RD;
            S_LO_RD:  n_state = S_LO_CAP;
            S_LO_CAP: begin
                if (r_single) begin
                    n_state = S_DONE;
                end else if (den == 16'd0 || (num_neg != den_neg && num != 16'd0)
                             || num >= den) begin
                    n_state = S_SQ;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV:    if (r_cnt == 4'd15) begin
                n_state = S_SQ;
            end
            S_SQ:     n_state = S_WT;
            S_WT:     n_state = S_BLEND;
            S_BLEND:  if (r_ch == 2'd2) begin
                n_state = S_DONE;
            end
            S_DONE:   if (!r_ov || m_axis_tready) begin
                n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode <= 1'b0;
            r_count <= 7'd0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SPLINE_MODE: r_mode <= i_cfg_data[0];
                    REG_STOP_COUNT:  r_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_DONE && (!r_ov || m_axis_tready)) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pos <= s_axis_tdata[54:39];
            r_i <= '0;
            r_single <= (n_stops < 8'd2);
        end
        if (r_state == S_HI_CHK) begin
            if ((i_ext + 8'd2 < n_stops) && (rd_pos16 < r_pos)) begin
                r_i <= AW'(r_i + 1'b1);
            end else begin
                r_hi_ent <= rd_data;
            end
        end
        if (r_state == S_LO_CAP) begin
            r_lo_ent <= rd_data;
            r_res <= rd_data[23:0];
            r_rem <= num;
            r_den <= den;
            r_cnt <= 4'd0;
            if (den == 16'd0 || (num_neg != den_neg && num != 16'd0)) begin
                r_d <= 17'd0;
            end else if (num >= den) begin
                r_d <= 17'd65536;
            end
        end
        if (r_state == S_DIV) begin
            r_cnt <= 4'(r_cnt + 1'b1);
            if (rem2 >= {1'b0, r_den}) begin
                r_rem <= 16'(rem2 - {1'b0, r_den});
                r_q <= {r_q[14:0], 1'b1};
            end else begin
                r_rem <= rem2[15:0];
                r_q <= {r_q[14:0], 1'b0};
            end
            if (r_cnt == 4'd15) begin
                r_d <= {1'b0, r_q[14:0], (rem2 >= {1'b0, r_den})};
            end
        end
        if (r_state == S_SQ) begin
            r_sq <= r_d * r_d;
            r_ch <= 2'd0;
        end
        if (r_state == S_WT) begin
            r_w <= r_mode ? cube[48:0] : {r_d, 32'd0};
        end
        if (r_state == S_BLEND) begin
            r_ch <= 2'(r_ch + 1'b1);
            unique case (r_ch)
                2'd0:    r_res[23:16] <= blend_res;
                2'd1:    r_res[15:8] <= blend_res;
                default: r_res[7:0] <= blend_res;
            endcase
        end
        if (r_state == S_DONE && (!r_ov || m_axis_tready)) begin
            r_out <= {r_res[7:0], r_res[15:8], r_res[23:16]};
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_out;

    `CGL_ASSERT_NOW(a_hi_in_range, r_state == S_HI_CHK, i_ext + 8'd1 < n_stops)
    `CGL_ASSERT_NOW(a_div_count, r_state == S_DIV, !r_single)
    `CGL_ASSERT_NOW(a_frac_range, r_state == S_SQ, r_d <= 17'd65536)
    `CGL_ASSERT_NEXT(a_blend_to_done, r_state == S_BLEND && r_ch == 2'd2, r_state == S_DONE)
endmodule

// ===== tb/color_gradient_lookup_tb.sv =====
// Self-checking testbench for the colour gradient lookup, with a predictor and stream checker.
`timescale 1ns / 100ps

module color_gradient_lookup_tb;
    import cgl_pkg::*;

    localparam int STOPS = 128;
    localparam int DRAIN_CYCLES = 320;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic        op;
        logic [6:0]  idx;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  spos;
        logic [15:0] pos;
    } t_stop_item;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // stop_index, stop_red, stop_green, stop_blue, stop_position, position, zero fill.
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    // operation.
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // out_red, out_green, out_blue.
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    color_gradient_lookup dut (.*);

    t_stop_item  item_q[$];
    logic [23:0] colour_q[$];
    t_stop_item  cur_item;
    logic [23:0] stop_rgb [STOPS];
    logic [7:0]  stop_pos [STOPS];
    logic        model_spline;
    logic [6:0]  model_count;
    int          errors;
    int          burst_left;
    int          gap_left;
    int          ready_mode;
    int          hold_cnt;
    int          idle_cycles;
    int          cycle_cnt;
    bit          hold_req;
    bit          hold_taken;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic logic [16:0] seg_fraction(input logic [31:0] p, input logic [31:0] lo,
                                                input logic [31:0] hi);
        logic        num_neg;
        logic        den_neg;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        num_neg = p < lo;
        den_neg = hi < lo;
        num = num_neg ? 64'(lo - p) : 64'(p - lo);
        den = den_neg ? 64'(lo - hi) : 64'(hi - lo);
        if (den == 0 || (num_neg != den_neg && num != 0)) return 17'd0;
        q = (num << 16) / den;
        return q > 64'd65536 ? 17'd65536 : q[16:0];
    endfunction

    function automatic logic [7:0] mix_channel(input logic [7:0] c1, input logic [7:0] c2,
                                               input logic [63:0] w);
        logic [63:0] v;
        v = (64'(c1) * ((64'd1 << 48) - w) + 64'(c2) * w) >> 48;
        return v > 255 ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [23:0] gradient_colour(input logic [15:0] p);
        int          seg;
        logic [63:0] d;
        logic [63:0] w;
        logic [23:0] lo_c;
        logic [23:0] hi_c;
        logic [23:0] res;
        if (model_count < 2) return stop_rgb[0];
        seg = 0;
        while (seg + 2 < model_count && 32'(stop_pos[seg + 1]) * 257 < 32'(p)) seg++;
        d = 64'(seg_fraction(32'(p), 32'(stop_pos[seg]) * 257, 32'(stop_pos[seg + 1]) * 257));
        w = model_spline ? 3 * d * d * 64'd65536 - 2 * d * d * d : d << 32;
        lo_c = stop_rgb[seg];
        hi_c = stop_rgb[seg + 1];
        res[7:0]   = mix_channel(lo_c[23:16], hi_c[23:16], w);
        res[15:8]  = mix_channel(lo_c[15:8], hi_c[15:8], w);
        res[23:16] = mix_channel(lo_c[7:0], hi_c[7:0], w);
        return res;
    endfunction

    always @(posedge i_clk) begin
        logic nv;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 1;
            gap_left = 0;
        end else begin
            nv = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                nv = 1'b0;
                if (cur_item.op == OP_WRITE) begin
                    stop_rgb[cur_item.idx] = {cur_item.red, cur_item.green, cur_item.blue};
                    stop_pos[cur_item.idx] = cur_item.spos;
                end else begin
                    colour_q.push_back(gradient_colour(cur_item.pos));
                end
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (item_q.size() != 0) begin
                    cur_item = item_q.pop_front();
                    s_axis_tuser <= cur_item.op;
                    s_axis_tdata <= {1'b0, cur_item.pos, cur_item.spos, cur_item.blue,
                                     cur_item.green, cur_item.red, cur_item.idx};
                    nv = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
                    end
                end
            end
            s_axis_tvalid <= nv;
        end
    end

    always @(posedge i_clk) begin
        logic [23:0] want;
        logic        rdy;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            ready_mode = 0;
            hold_cnt = 0;
            cycle_cnt = 0;
        end else begin
            cycle_cnt++;
            if (m_axis_tvalid && m_axis_tready) begin
                if (colour_q.size() == 0) begin
                    $display("unexpected beat %h at %0t", m_axis_tdata, $time);
                    errors++;
                end else begin
                    want = colour_q.pop_front();
                    if (m_axis_tdata[7:0] !== want[7:0])
                        report("out_red", m_axis_tdata[7:0], want[7:0]);
                    if (m_axis_tdata[15:8] !== want[15:8])
                        report("out_green", m_axis_tdata[15:8], want[15:8]);
                    if (m_axis_tdata[23:16] !== want[23:16])
                        report("out_blue", m_axis_tdata[23:16], want[23:16]);
                end
            end
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_cnt = 600;
            end
            if (cycle_cnt % 64 == 0) ready_mode = $urandom_range(0, 2);
            if (hold_cnt > 0) begin
                hold_cnt--;
                rdy = 1'b0;
            end else begin
                case (ready_mode)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    default: rdy = (cycle_cnt % 7) > 2;
                endcase
            end
            m_axis_tready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("color_gradient_lookup verification failed");
                $finish;
            end
        end
    end

    task automatic push_stop(input int idx, input logic [23:0] rgb, input logic [7:0] p);
        t_stop_item it;
        it = '0;
        it.op = OP_WRITE;
        it.idx = 7'(idx);
        {it.red, it.green, it.blue} = rgb;
        it.spos = p;
        it.pos = 16'($urandom);
        item_q.push_back(it);
    endtask

    task automatic push_lookup(input logic [15:0] p);
        t_stop_item it;
        it = '0;
        it.op = OP_LOOKUP;
        it.idx = 7'($urandom);
        it.red = 8'($urandom);
        it.green = 8'($urandom);
        it.blue = 8'($urandom);
        it.spos = 8'($urandom);
        it.pos = p;
        item_q.push_back(it);
    endtask

    task automatic wait_idle();
        while (item_q.size() != 0 || s_axis_tvalid || colour_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_gradient(input logic spline, input logic [6:0] cnt);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_SPLINE_MODE;
        i_cfg_data <= CFG_DATA_W'(spline);
        @(posedge i_clk);
        i_cfg_idx <= REG_STOP_COUNT;
        i_cfg_data <= cnt;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_spline = spline;
        model_count = cnt;
    endtask

    task automatic lay_stops(input int cnt, input bit sorted);
        int p;
        p = 0;
        for (int k = 0; k < cnt; k++) begin
            if (sorted) p = (k == 0) ? $urandom_range(0, 20)
                                     : p + $urandom_range(0, 2 * 255 / cnt + 1);
            if (p > 255) p = 255;
            push_stop(k, 24'($urandom), sorted ? p[7:0] : 8'($urandom));
        end
    endtask

    initial begin
        int cnt;
        int n_items;
        logic [15:0] p;
        errors = 0;
        hold_req = 1'b0;
        hold_taken = 1'b0;
        model_spline = 1'b0;
        model_count = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < STOPS; k++) push_stop(k, 24'($urandom), 8'(k * 2));
        push_stop(0, 24'h000000, 8'd0);
        push_stop(1, 24'hFFFFFF, 8'd255);
        push_stop(127, 24'hFFFFFF, 8'd255);
        push_lookup(16'd0);
        push_lookup(16'hFFFF);
        wait_idle();
        set_gradient(1'b0, 7'd1);
        push_lookup(16'd1234);
        push_lookup(16'h8000);
        push_lookup(16'hFFFF);
        push_lookup(16'd0);
        wait_idle();
        set_gradient(1'b1, 7'd2);
        push_lookup(16'h8000);
        push_lookup(16'hFFFF);
        push_stop(0, 24'h10FF20, 8'd100);
        push_stop(1, 24'hF0007F, 8'd100);
        push_lookup(16'd25700);
        push_lookup(16'd40000);
        push_stop(1, 24'hF0007F, 8'd50);
        push_lookup(16'd5000);
        push_lookup(16'd20000);
        push_lookup(16'd60000);
        wait_idle();
        set_gradient(1'b0, 7'd127);
        push_lookup(16'd0);
        push_lookup(16'hFFFF);
        push_lookup(16'd20000);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            cnt = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 10) : $urandom_range(0, 127);
            if (ph == 3) cnt = 127;
            set_gradient(1'($urandom_range(0, 1)), 7'(cnt));
            lay_stops(cnt < 2 ? 2 : cnt, $urandom_range(0, 9) < 7);
            if (ph == 5) hold_req = 1'b1;
            n_items = (cnt > 40) ? 30 : 75;
            for (int k = 0; k < n_items; k++) begin
                if ($urandom_range(0, 9) < 2) begin
                    push_stop($urandom_range(0, cnt < 2 ? 1 : cnt - 1), 24'($urandom),
                              8'($urandom));
                end else begin
                    case ($urandom_range(0, 3))
                        0: p = 16'(32'(stop_pos[$urandom_range(0, cnt < 2 ? 1 : cnt - 1)])
                                   * 257 + $urandom_range(0, 2) - 1);
                        1: p = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                        default: p = 16'($urandom);
                    endcase
                    push_lookup(p);
                end
            end
            wait_idle();
        end

        if (errors == 0 && colour_q.size() == 0) begin
            $display("color_gradient_lookup verification clean");
        end else begin
            $display("color_gradient_lookup verification failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/cgl_pkg.sv
rtl/cgl_ram.sv
rtl/color_gradient_lookup.sv
tb/color_gradient_lookup_tb.sv
